### rtl/core/hku_pkg.sv
// Shared types, sizes and helpers for the history/killer update block.
// Used by hku_front, hku_back and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hku_pkg;

  // Store sizes
  localparam int MAX_PLY      = 64;                  // killer rows, 2..256
  localparam int MOVE_BITS    = 21;                  // stored move width, 12..32
  localparam int HIST_IDX_W   = 12;                  // to/from squares
  localparam int HIST_ENTRIES = 1 << HIST_IDX_W;     // per side
  localparam int HIST_DEPTH   = 2 * HIST_ENTRIES;    // both sides in one memory
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int KAW          = (MAX_PLY > 2) ? $clog2(MAX_PLY) : 1;

  // Field widths
  localparam int FIELD_MOVE_W = 21;
  localparam int PLY_W        = 6;
  localparam int DEPTH_W      = 6;
  localparam int SQ_W         = 2 * DEPTH_W;
  localparam int HIST_W       = 32;
  localparam int COUNT_W      = 16;
  localparam int PLY_CMP_W    = 9;                   // holds MAX_PLY up to 256

  // Queue sizes (powers of two so the pointers wrap on their own)
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [FIELD_MOVE_W-1:0] move_code;
    logic                    is_tactical;
    logic [PLY_W-1:0]        ply_level;
    logic [DEPTH_W-1:0]      search_depth;
    logic                    white_side;
  } in_item_t;

  typedef struct packed {
    logic                    skipped;
    logic [HIST_W-1:0]       history_value;
    logic [FIELD_MOVE_W-1:0] killer_first;
    logic [FIELD_MOVE_W-1:0] killer_second;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [MOVE_BITS-1:0] mv;
    logic                 tactical;
    logic                 ply_ok;
    logic [KAW-1:0]       kaddr;
    logic [HIST_AW-1:0]   haddr;
    logic [SQ_W-1:0]      add;
  } cmd_t;

  // One killer row: both entries of a ply
  typedef struct packed {
    logic [MOVE_BITS-1:0] move_a;
    logic [MOVE_BITS-1:0] move_b;
    logic [COUNT_W-1:0]   count_a;
    logic [COUNT_W-1:0]   count_b;
  } krow_t;

  localparam int KROW_W = $bits(krow_t);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

  // Saturating killer count increment
  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

### rtl/core/hku_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hku_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hku_front.sv
// Front end: accepts input beats, classifies them into commands and queues
// them for the back end. Depends on hku_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hku_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output      logic              in_full,
  input  wire hku_pkg::in_item_t in_data,
  input  wire logic              back_ready,
  output      logic              cmd_valid,
  output      hku_pkg::cmd_t     cmd,
  input  wire logic              cmd_pop
);

  import hku_pkg::*;

  cmd_t             q_mem [FQ_DEPTH];
  logic [FQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;
  cmd_t             cls;
  logic [MOVE_BITS-1:0] mv;

  // Classify the incoming beat
  always_comb begin
    mv           = MOVE_BITS'(in_data.move_code);
    cls.mv       = mv;
    cls.tactical = in_data.is_tactical;
    cls.ply_ok   = PLY_CMP_W'(in_data.ply_level) < PLY_CMP_W'(MAX_PLY);
    cls.kaddr    = KAW'(in_data.ply_level);
    cls.haddr    = {in_data.white_side, mv[HIST_IDX_W-1:0]};
    cls.add      = SQ_W'(in_data.search_depth) * SQ_W'(in_data.search_depth);
  end

  // Queue control
  assign in_full   = (cnt_r == FQ_CW'(FQ_DEPTH)) || !back_ready;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? FQ_PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok  ? FQ_PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = FQ_CW'(cnt_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = FQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hku_back.sv
// Back end: clears the stores after reset, then runs one read-modify-write
// of the history and killer memories per command and queues the results.
// Depends on hku_pkg and hku_ram.
`timescale 1ns / 1ps
`default_nettype none

module hku_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  output      logic               back_ready,
  input  wire logic               cmd_valid,
  input  wire hku_pkg::cmd_t      cmd,
  output      logic               cmd_pop,
  output      logic               out_empty,
  input  wire logic               out_pop,
  output      hku_pkg::out_item_t out_data
);

  import hku_pkg::*;

  back_state_t        st_r, st_nxt;
  logic [HIST_AW-1:0] sweep_cnt_r, sweep_cnt_nxt;
  cmd_t               cur_r;

  logic               h_we, h_re;
  logic [HIST_AW-1:0] h_waddr, h_raddr;
  logic [HIST_W-1:0]  h_wdata, h_rdata;
  logic               k_we, k_re;
  logic [KAW-1:0]     k_waddr, k_raddr;
  krow_t              k_wdata, k_rdata;

  logic [HIST_W:0]    hist_sum;
  logic [HIST_W-1:0]  hist_new;
  logic [HIST_W-1:0]  hist_val;
  krow_t              krow_new;
  krow_t              krow_out;
  logic               hit_a, hit_b;
  logic [COUNT_W-1:0] cb_inc;
  out_item_t          res;

  out_item_t          oq_mem [OQ_DEPTH];
  logic [OQ_PW-1:0]   oq_wr_r, oq_wr_nxt;
  logic [OQ_PW-1:0]   oq_rd_r, oq_rd_nxt;
  logic [OQ_CW-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic               oq_push, oq_pop;

  hku_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  hku_ram #(.WIDTH(KROW_W), .DEPTH(MAX_PLY)) u_killer_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // Saturating history update
  always_comb begin
    hist_sum = {1'b0, h_rdata} + (HIST_W + 1)'(cur_r.add);
    hist_new = hist_sum[HIST_W] ? {HIST_W{1'b1}} : hist_sum[HIST_W-1:0];
    hist_val = cur_r.tactical ? h_rdata : hist_new;
  end

  // Killer pair update
  always_comb begin
    hit_a    = (k_rdata.move_a == cur_r.mv);
    hit_b    = (k_rdata.move_b == cur_r.mv);
    cb_inc   = count_inc(k_rdata.count_b);
    krow_new = k_rdata;
    if (hit_a) begin
      krow_new.count_a = count_inc(k_rdata.count_a);
    end else if (hit_b) begin
      if (k_rdata.count_a < cb_inc) begin
        krow_new.move_a  = k_rdata.move_b;
        krow_new.count_a = cb_inc;
        krow_new.move_b  = k_rdata.move_a;
        krow_new.count_b = k_rdata.count_a;
      end else begin
        krow_new.count_b = cb_inc;
      end
    end else begin
      krow_new.move_b  = cur_r.mv;
      krow_new.count_b = COUNT_W'(1);
    end
    krow_out = (cur_r.tactical || !cur_r.ply_ok) ? k_rdata : krow_new;
  end

  // Assemble the result beat
  always_comb begin
    res.skipped       = cur_r.tactical;
    res.history_value = hist_val;
    res.killer_first  = cur_r.ply_ok ? FIELD_MOVE_W'(krow_out.move_a) : '0;
    res.killer_second = cur_r.ply_ok ? FIELD_MOVE_W'(krow_out.move_b) : '0;
  end

  // Sequencer: clear sweep, then issue read, then write back
  always_comb begin
    st_nxt        = st_r;
    sweep_cnt_nxt = sweep_cnt_r;
    cmd_pop       = 1'b0;
    h_we          = 1'b0;
    h_waddr       = sweep_cnt_r;
    h_wdata       = '0;
    h_re          = 1'b0;
    h_raddr       = cmd.haddr;
    k_we          = 1'b0;
    k_waddr       = KAW'(sweep_cnt_r);
    k_wdata       = '0;
    k_re          = 1'b0;
    k_raddr       = cmd.kaddr;
    oq_push       = 1'b0;
    case (st_r)
      ST_SWEEP: begin
        h_we          = 1'b1;
        k_we          = sweep_cnt_r < HIST_AW'(MAX_PLY);
        sweep_cnt_nxt = HIST_AW'(sweep_cnt_r + 1'b1);
        if (sweep_cnt_r == HIST_AW'(HIST_DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && (oq_cnt_r != OQ_CW'(OQ_DEPTH))) begin
          cmd_pop = 1'b1;
          h_re    = 1'b1;
          k_re    = 1'b1;
          st_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        h_we    = !cur_r.tactical;
        h_waddr = cur_r.haddr;
        h_wdata = hist_new;
        k_we    = !cur_r.tactical && cur_r.ply_ok;
        k_waddr = cur_r.kaddr;
        k_wdata = krow_new;
        oq_push = 1'b1;
        st_nxt  = ST_IDLE;
      end
      default: begin
        st_nxt = ST_SWEEP;
      end
    endcase
  end

  assign back_ready = (st_r != ST_SWEEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SWEEP;
      sweep_cnt_r <= '0;
    end else begin
      st_r        <= st_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  // Hold the command in flight
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
  end

  // Result queue
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_mem[oq_rd_r];

  always_comb begin
    oq_wr_nxt  = oq_push ? OQ_PW'(oq_wr_r + 1'b1) : oq_wr_r;
    oq_rd_nxt  = oq_pop  ? OQ_PW'(oq_rd_r + 1'b1) : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = OQ_CW'(oq_cnt_r + 1'b1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = OQ_CW'(oq_cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

  // Checks
  a_update_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPDATE) |-> (oq_cnt_r != OQ_CW'(OQ_DEPTH)))
    else $error("result queue full during write back");

  a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPDATE) |=> (st_r == ST_IDLE))
    else $error("write back longer than one cycle");

  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_SWEEP) |=> (st_r != ST_SWEEP))
    else $error("clear sweep restarted without reset");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SWEEP) |-> (!cmd_pop && !oq_push))
    else $error("command taken during clear sweep");

endmodule

`default_nettype wire

### rtl/core/history_killer_update.sv
// With the back end idle, an accepted input beat goes through the front
// queue, a memory read and a write back before its result is visible.
// A new command is taken only after the last is written back, since the
// history and killer memories are read, then written (one port pair each).
// Reset: synchronous, active low; afterwards a clear sweep over all 8192
// history addresses zeroes both memories while in_full stays high.
// Top level: front end, back end. Depends on hku_pkg, hku_front, hku_back.
`timescale 1ns / 1ps
`default_nettype none

module history_killer_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output      logic               in_full,
  input  wire hku_pkg::in_item_t  in_data,
  output      logic               out_empty,
  input  wire logic               out_pop,
  output      hku_pkg::out_item_t out_data
);

  import hku_pkg::*;

  logic back_ready;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  hku_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .back_ready (back_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  hku_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .back_ready (back_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### test/history_killer_update_tb.sv
// Testbench for history_killer_update: history counters and killer pairs per ply.
// Depends on hku_pkg and history_killer_update; compares each result beat
// against an in-bench model of the stores, or a directed row's expected values.
`timescale 1ns / 1ps

module history_killer_update_tb;
  import hku_pkg::*;

  localparam int RANDOM_MOVES  = 1130;    // random beats
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  // Model of the block's stores
  logic [HIST_W-1:0]       hist_white [HIST_ENTRIES];
  logic [HIST_W-1:0]       hist_black [HIST_ENTRIES];
  logic [MOVE_BITS-1:0]    killer_a_move [MAX_PLY];
  logic [MOVE_BITS-1:0]    killer_b_move [MAX_PLY];
  logic [COUNT_W-1:0]      killer_a_hits [MAX_PLY];
  logic [COUNT_W-1:0]      killer_b_hits [MAX_PLY];

  out_item_t due_reports[$];
  out_item_t head_report;
  dir_row_t  dir_rows[$];
  int        mismatch_cnt = 0;
  int        pop_hold = 0;
  bit        no_idle = 1'b0;

  history_killer_update DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Apply one refuting move to the model and return what the block reports
  function automatic out_item_t apply_refutation(input in_item_t it);
    logic [MOVE_BITS-1:0]  mv;
    logic [HIST_IDX_W-1:0] idx;
    logic [SQ_W-1:0]       add;
    logic [HIST_W:0]       sum;
    logic [HIST_W-1:0]     cur;
    logic [COUNT_W-1:0]    tc;
    logic [MOVE_BITS-1:0]  tm;
    bit                    ply_ok;
    int                    p;
    out_item_t             res;

    // upper move bits beyond the stored width are dropped
    mv     = MOVE_BITS'(it.move_code);
    idx    = it.move_code[HIST_IDX_W-1:0];
    add    = SQ_W'(it.search_depth) * SQ_W'(it.search_depth);
    p      = int'(it.ply_level);
    ply_ok = p < MAX_PLY;

    if (!it.is_tactical) begin
      // saturating history add
      cur = it.white_side ? hist_white[idx] : hist_black[idx];
      sum = {1'b0, cur} + add;
      cur = sum[HIST_W] ? {HIST_W{1'b1}} : sum[HIST_W-1:0];
      if (it.white_side) hist_white[idx] = cur;
      else hist_black[idx] = cur;

      // killer pair: hit on first, hit on second with promotion, or replace second
      if (ply_ok) begin
        if (killer_a_move[p] == mv) begin
          killer_a_hits[p] = bump_count(killer_a_hits[p]);
        end else if (killer_b_move[p] == mv) begin
          killer_b_hits[p] = bump_count(killer_b_hits[p]);
          if (killer_a_hits[p] < killer_b_hits[p]) begin
            tc = killer_a_hits[p];
            tm = killer_a_move[p];
            killer_a_hits[p] = killer_b_hits[p];
            killer_a_move[p] = killer_b_move[p];
            killer_b_hits[p] = tc;
            killer_b_move[p] = tm;
          end
        end else begin
          killer_b_move[p] = mv;
          killer_b_hits[p] = COUNT_W'(1);
        end
      end
    end

    res.skipped       = it.is_tactical;
    res.history_value = it.white_side ? hist_white[idx] : hist_black[idx];
    res.killer_first  = ply_ok ? FIELD_MOVE_W'(killer_a_move[p]) : '0;
    res.killer_second = ply_ok ? FIELD_MOVE_W'(killer_b_move[p]) : '0;
    return res;
  endfunction

  // Drive one beat after a gap; queue its expected report once accepted
  task automatic drive_beat(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    res = apply_refutation(it);
    due_reports.push_back(typed ? want : res);
  endtask

  // Drop push, then hold until every queued report has come back
  task automatic drain_reports();
    @(negedge clk);
    in_push <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [FIELD_MOVE_W-1:0] mv, input bit tac,
                         input logic [PLY_W-1:0] ply, input logic [DEPTH_W-1:0] dep,
                         input bit white, input bit typed, input bit skip,
                         input logic [HIST_W-1:0] hist,
                         input logic [FIELD_MOVE_W-1:0] first,
                         input logic [FIELD_MOVE_W-1:0] second);
    dir_row_t row;
    row.beat.move_code    = mv;
    row.beat.is_tactical  = tac;
    row.beat.ply_level    = ply;
    row.beat.search_depth = dep;
    row.beat.white_side   = white;
    row.typed             = typed;
    row.want.skipped       = skip;
    row.want.history_value = hist;
    row.want.killer_first  = first;
    row.want.killer_second = second;
    dir_rows.push_back(row);
  endtask

  // Result side: pop with random stalls, check each beat against the oldest report
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0 && !no_idle) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        pop_hold = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (due_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("result beat with nothing pending: %p", out_data);
      end else begin
        head_report = due_reports.pop_front();
        if (out_data.skipped !== head_report.skipped ||
            out_data.history_value !== head_report.history_value ||
            out_data.killer_first !== head_report.killer_first ||
            out_data.killer_second !== head_report.killer_second) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch (exp/got): skipped %0b/%0b history %0d/%0d",
                     head_report.skipped, out_data.skipped,
                     head_report.history_value, out_data.history_value,
                     " first %h/%h second %h/%h",
                     head_report.killer_first, out_data.killer_first,
                     head_report.killer_second, out_data.killer_second);
        end
      end
      pop_hold = pick_gap();
    end
  end

  // Stimulus
  initial begin
    in_item_t             it;
    out_item_t            none;
    logic [MOVE_BITS-1:0] move_pool [8];
    logic [PLY_W-1:0]     hot_ply [6];
    int                   kept;
    bit                   paused;

    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    none    = '0;
    foreach (hist_white[i]) begin
      hist_white[i] = '0;
      hist_black[i] = '0;
    end
    foreach (killer_a_move[i]) begin
      killer_a_move[i] = '0;
      killer_b_move[i] = '0;
      killer_a_hits[i] = '0;
      killer_b_hits[i] = '0;
    end

    // Directed rows: fresh stores, extremes, first/second hits, tactical skips
    add_row(21'h1FFFFF, 1, 63, 63, 1, 1, 1, 0,     21'h000000, 21'h000000);
    add_row(21'h1FFFFF, 0, 63, 63, 1, 1, 0, 3969,  21'h000000, 21'h1FFFFF);
    add_row(21'h1FFFFF, 0, 63, 63, 1, 1, 0, 7938,  21'h1FFFFF, 21'h000000);
    add_row(21'h1FFFFF, 0, 63, 63, 1, 1, 0, 11907, 21'h1FFFFF, 21'h000000);
    add_row(21'h000000, 0, 0,  0,  0, 1, 0, 0,     21'h000000, 21'h000000);
    add_row(21'h000FFF, 0, 0,  1,  0, 1, 0, 1,     21'h000000, 21'h000FFF);
    add_row(21'h1FF000, 0, 0,  2,  1, 1, 0, 4,     21'h000000, 21'h1FF000);
    add_row(21'h1FF000, 0, 0,  2,  1, 1, 0, 8,     21'h1FF000, 21'h000000);
    add_row(21'h1FF000, 1, 0,  63, 1, 1, 1, 8,     21'h1FF000, 21'h000000);
    add_row(21'h155ABC, 1, 5,  63, 1, 1, 1, 0,     21'h000000, 21'h000000);
    add_row(21'h1FFFFF, 0, 63, 63, 0, 1, 0, 3970,  21'h1FFFFF, 21'h000000);
    add_row(21'h0AAFFF, 0, 63, 1,  0, 1, 0, 3971,  21'h1FFFFF, 21'h0AAFFF);
    add_row(21'h0AAFFF, 0, 63, 0,  0, 1, 0, 3971,  21'h1FFFFF, 21'h0AAFFF);
    // second count climbs to equal the first (no swap), then passes it
    add_row(21'h0AAFFF, 0, 63, 5,  1, 0, 0, 0, 0, 0);
    add_row(21'h0AAFFF, 0, 63, 5,  1, 0, 0, 0, 0, 0);
    add_row(21'h0AAFFF, 0, 63, 5,  1, 0, 0, 0, 0, 0);
    add_row(21'h0AAAAA, 0, 31, 21, 1, 0, 0, 0, 0, 0);
    add_row(21'h155555, 0, 42, 42, 0, 0, 0, 0, 0, 0);
    add_row(21'h155555, 1, 42, 42, 0, 0, 0, 0, 0, 0);

    foreach (move_pool[i]) begin
      if (i < 4) move_pool[i] = MOVE_BITS'($urandom);
      else move_pool[i] = {~move_pool[i-4][MOVE_BITS-1:HIST_IDX_W],
                           move_pool[i-4][HIST_IDX_W-1:0]};
    end
    hot_ply[0] = 0;
    hot_ply[1] = 1;
    hot_ply[2] = 2;
    hot_ply[3] = 62;
    hot_ply[4] = 63;
    hot_ply[5] = PLY_W'($urandom);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain_reports();

    // Random part: mostly repeated moves on a few plies, some wide noise
    kept   = 0;
    paused = 1'b0;
    while (kept < RANDOM_MOVES) begin
      if (kept % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (!paused && kept == RANDOM_MOVES / 2) begin
        drain_reports();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 75) begin
        it.ply_level = hot_ply[$urandom_range(0, 5)];
        it.move_code = FIELD_MOVE_W'(move_pool[$urandom_range(0, 7)]);
      end else begin
        it.ply_level = PLY_W'($urandom);
        it.move_code = FIELD_MOVE_W'($urandom);
      end
      it.is_tactical  = ($urandom_range(0, 7) == 0);
      it.search_depth = DEPTH_W'($urandom);
      it.white_side   = $urandom_range(0, 1);
      drive_beat(it, 1'b0, none);
      kept++;
    end

    @(negedge clk);
    in_push <= 1'b0;
    no_idle = 1'b0;
    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && due_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
